>>> src/blm_pkg.sv
// Shared types and constants of the battery level monitor.
// Depends on nothing; every other file takes names from it by scope.
package blm_pkg;

    localparam int MV_W       = 13;
    localparam int ADC_W      = 12;
    localparam int PCT_W      = 7;
    localparam int TIME_W     = 32;
    localparam int DIV_NUM_W  = 19;
    localparam int DIV_DEN_W  = 7;
    localparam int DIV_CNT_W  = 5;
    localparam int PCT_PROD_W = 23;

    localparam logic [MV_W-1:0] MV_FULL = 13'd4150;
    localparam logic [MV_W-1:0] MV_HIGH = 13'd3820;
    localparam logic [MV_W-1:0] MV_MID  = 13'd3500;
    localparam logic [MV_W-1:0] MV_LOW  = 13'd3300;
    localparam logic [MV_W-1:0] MV_EMPTY = 13'd3000;

    // Reciprocal multipliers of three charge curve segments, each exact for the segment's
    // whole span: 5/33 scaled by 2^16, 1/40 by 2^13 and 1/60 by 2^15.
    localparam logic [PCT_PROD_W-1:0] RCP_HIGH  = 23'd9930;
    localparam logic [PCT_PROD_W-1:0] RCP_LOW   = 23'd205;
    localparam logic [PCT_PROD_W-1:0] RCP_EMPTY = 23'd547;
    localparam int SH_HIGH  = 16;
    localparam int SH_LOW   = 13;
    localparam int SH_EMPTY = 15;

    localparam logic [PCT_W-1:0] PCT_RESET = 7'd100;
    localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd10000;

    localparam logic [0:0] REG_TIMEOUT = 1'b0;

    typedef enum logic [0:0] {
        OP_SAMPLE   = 1'b0,
        OP_ACTIVITY = 1'b1
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [MV_W-1:0]   mv;
        logic [TIME_W-1:0] now_ms;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_queue_head;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
        logic [DIV_CNT_W-1:0] bits;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quo;
    } t_div_rsp;

endpackage

>>> src/blm_front.sv
// Front end of the battery level monitor: accepts requests, classifies them
// and holds them in a two-entry queue. Depends on blm_pkg.
module blm_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_operation,
    input  logic [blm_pkg::ADC_W-1:0]     i_adc_millivolts,
    input  logic [blm_pkg::TIME_W-1:0]    i_now_ms,
    output blm_pkg::t_queue_head          o_head,
    input  logic                          i_pop
);

    blm_pkg::t_item r_entry [2];
    logic           r_wr_ptr, n_wr_ptr;
    logic           r_rd_ptr, n_rd_ptr;
    logic [1:0]     r_count, n_count;
    logic           push;
    logic           pop;
    blm_pkg::t_item in_item;

    // Battery voltage is twice the divided ADC reading.
    always_comb begin
        in_item.op     = blm_pkg::t_op'(i_operation);
        in_item.mv     = {i_adc_millivolts, 1'b0};
        in_item.now_ms = i_now_ms;
    end

    assign o_in_stall   = (r_count == 2'd2);
    assign push         = i_in_valid && !o_in_stall;
    assign pop          = i_pop && (r_count != 2'd0);
    assign o_head.valid = (r_count != 2'd0);
    assign o_head.item  = r_entry[r_rd_ptr];

    always_comb begin
        n_wr_ptr = push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count;
        if (push && !pop) begin
            n_count = r_count + 2'd1;
        end else if (pop && !push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_entry[r_wr_ptr] <= in_item;
        end
    end

endmodule

>>> src/blm_div.sv
// Restoring divider, one quotient bit per cycle.
// The request gives the numerator width so short divisions finish early. Depends on blm_pkg.
module blm_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  blm_pkg::t_div_req i_req,
    output blm_pkg::t_div_rsp o_rsp
);

    localparam int NW = blm_pkg::DIV_NUM_W;
    localparam int DW = blm_pkg::DIV_DEN_W;
    localparam int CW = blm_pkg::DIV_CNT_W;

    logic [NW-1:0] r_quo;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [CW-1:0] r_left;
    logic          r_busy;
    logic          r_done;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;
    logic [CW-1:0] shamt;

    assign trial = {r_rem, r_quo[NW-1]};
    assign diff  = trial - {1'b0, r_den};
    assign ge    = (trial >= {1'b0, r_den});
    assign shamt = CW'(NW) - i_req.bits;

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_left <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_left <= i_req.bits;
        end else if (r_busy) begin
            r_left <= r_left - CW'(1);
            if (r_left == CW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.num << shamt;
            r_rem <= '0;
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_quo <= {r_quo[NW-2:0], ge};
            r_rem <= ge ? diff[DW-1:0] : trial[DW-1:0];
        end
    end

endmodule

>>> src/blm_back.sv
// Back end of the battery level monitor: sample ring, running sum, average through the
// divider, charge curve by reciprocal multiplication, screen timeout and result register.
// Depends on blm_pkg.
module blm_back #(
    parameter int WINDOW_DEPTH = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  blm_pkg::t_queue_head          i_head,
    output logic                          o_pop,
    input  logic [blm_pkg::TIME_W-1:0]    i_timeout_ms,
    output blm_pkg::t_div_req             o_div_req,
    input  blm_pkg::t_div_rsp             i_div_rsp,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [blm_pkg::MV_W-1:0]      o_battery_millivolts,
    output logic [blm_pkg::PCT_W-1:0]     o_charge_percent,
    output logic                          o_low_battery,
    output logic                          o_screen_on
);

    localparam int MW    = blm_pkg::MV_W;
    localparam int POS_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W = MW + $clog2(WINDOW_DEPTH);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_ACC  = 6'b000010,
        ST_AVG  = 6'b000100,
        ST_PSET = 6'b001000,
        ST_PCT  = 6'b010000,
        ST_OUT  = 6'b100000
    } t_bstate;

    t_bstate r_state, n_state;

    logic [MW-1:0]    r_store [WINDOW_DEPTH];
    logic [MW-1:0]    r_rd_data;
    logic             mem_we;

    blm_pkg::t_item   r_item;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [SUM_W-1:0] r_sum, n_sum;
    logic [blm_pkg::TIME_W-1:0] r_last, n_last;
    logic             r_disp, n_disp;
    logic [MW-1:0]    r_held_mv, n_held_mv;
    logic [blm_pkg::PCT_W-1:0] r_held_pct, n_held_pct;
    logic             r_held_low, n_held_low;
    logic [blm_pkg::PCT_W-1:0] r_base, n_base;
    logic [blm_pkg::PCT_W-1:0] r_pct_q, n_pct_q;
    logic             r_out_valid;
    logic             out_load;
    logic             full;
    logic [blm_pkg::TIME_W-1:0] elapsed;

    logic [MW-1:0]    seg_x;
    logic [blm_pkg::PCT_PROD_W-1:0] pct_prod;
    logic [blm_pkg::PCT_W-1:0]      pct_quo;
    logic [blm_pkg::PCT_W-1:0]      pct_base;

    assign full    = (r_cnt == CNT_W'(WINDOW_DEPTH));
    assign elapsed = r_item.now_ms - r_last;
    assign out_load = (r_state == ST_OUT) && (!r_out_valid || !i_out_stall);
    assign o_pop   = (r_state == ST_IDLE) && i_head.valid;
    assign mem_we  = (r_state == ST_ACC);

    // Segment of the charge curve: base percentage plus a floor division by a constant, done
    // by scaled reciprocal multiplication and a shift, or by a shift alone for the middle one.
    always_comb begin
        seg_x    = '0;
        pct_prod = '0;
        pct_quo  = '0;
        pct_base = '0;
        if (r_held_mv >= blm_pkg::MV_FULL) begin
            pct_base = 7'd100;
        end else if (r_held_mv >= blm_pkg::MV_HIGH) begin
            seg_x    = r_held_mv - blm_pkg::MV_HIGH;
            pct_prod = blm_pkg::PCT_PROD_W'(seg_x[8:0]) * blm_pkg::RCP_HIGH;
            pct_quo  = pct_prod[blm_pkg::SH_HIGH +: blm_pkg::PCT_W];
            pct_base = 7'd50;
        end else if (r_held_mv >= blm_pkg::MV_MID) begin
            seg_x    = r_held_mv - blm_pkg::MV_MID;
            pct_quo  = {1'b0, seg_x[8:3]};
            pct_base = 7'd10;
        end else if (r_held_mv >= blm_pkg::MV_LOW) begin
            seg_x    = r_held_mv - blm_pkg::MV_LOW;
            pct_prod = blm_pkg::PCT_PROD_W'(seg_x[8:0]) * blm_pkg::RCP_LOW;
            pct_quo  = pct_prod[blm_pkg::SH_LOW +: blm_pkg::PCT_W];
            pct_base = 7'd5;
        end else if (r_held_mv >= blm_pkg::MV_EMPTY) begin
            seg_x    = r_held_mv - blm_pkg::MV_EMPTY;
            pct_prod = blm_pkg::PCT_PROD_W'(seg_x[8:0]) * blm_pkg::RCP_EMPTY;
            pct_quo  = pct_prod[blm_pkg::SH_EMPTY +: blm_pkg::PCT_W];
        end
    end

    always_comb begin
        n_state    = r_state;
        n_pos      = r_pos;
        n_cnt      = r_cnt;
        n_sum      = r_sum;
        n_last     = r_last;
        n_disp     = r_disp;
        n_held_mv  = r_held_mv;
        n_held_pct = r_held_pct;
        n_held_low = r_held_low;
        n_base     = r_base;
        n_pct_q    = r_pct_q;
        o_div_req.start = 1'b0;
        o_div_req.num   = '0;
        o_div_req.den   = blm_pkg::DIV_DEN_W'(1);
        o_div_req.bits  = blm_pkg::DIV_CNT_W'(SUM_W);
        unique case (r_state)
            ST_IDLE: begin
                if (i_head.valid) begin
                    if (i_head.item.op == blm_pkg::OP_ACTIVITY) begin
                        n_last  = i_head.item.now_ms;
                        n_disp  = 1'b1;
                        n_state = ST_OUT;
                    end else begin
                        n_state = ST_ACC;
                    end
                end
            end
            ST_ACC: begin
                if (full) begin
                    n_sum = r_sum - SUM_W'(r_rd_data) + SUM_W'(r_item.mv);
                end else begin
                    n_sum = r_sum + SUM_W'(r_item.mv);
                    n_cnt = r_cnt + CNT_W'(1);
                end
                n_pos = (r_pos == POS_W'(WINDOW_DEPTH - 1)) ? '0 : r_pos + POS_W'(1);
                if (r_disp && (elapsed >= i_timeout_ms)) begin
                    n_disp = 1'b0;
                end
                o_div_req.start = 1'b1;
                o_div_req.num   = blm_pkg::DIV_NUM_W'(n_sum);
                o_div_req.den   = blm_pkg::DIV_DEN_W'(n_cnt);
                o_div_req.bits  = blm_pkg::DIV_CNT_W'(SUM_W);
                n_state = ST_AVG;
            end
            ST_AVG: begin
                if (i_div_rsp.done) begin
                    n_held_mv  = i_div_rsp.quo[MW-1:0];
                    n_held_low = (i_div_rsp.quo[MW-1:0] < blm_pkg::MV_LOW);
                    n_state    = ST_PSET;
                end
            end
            ST_PSET: begin
                n_pct_q = pct_quo;
                n_base  = pct_base;
                n_state = ST_PCT;
            end
            ST_PCT: begin
                n_held_pct = r_base + r_pct_q;
                n_state    = ST_OUT;
            end
            ST_OUT: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pos       <= '0;
            r_cnt       <= '0;
            r_sum       <= '0;
            r_last      <= '0;
            r_disp      <= 1'b1;
            r_held_mv   <= '0;
            r_held_pct  <= blm_pkg::PCT_RESET;
            r_held_low  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_pos      <= n_pos;
            r_cnt      <= n_cnt;
            r_sum      <= n_sum;
            r_last     <= n_last;
            r_disp     <= n_disp;
            r_held_mv  <= n_held_mv;
            r_held_pct <= n_held_pct;
            r_held_low <= n_held_low;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_base  <= n_base;
        r_pct_q <= n_pct_q;
        if (o_pop) begin
            r_item <= i_head.item;
        end
        if (out_load) begin
            o_battery_millivolts <= r_held_mv;
            o_charge_percent     <= r_held_pct;
            o_low_battery        <= r_held_low;
            o_screen_on          <= r_disp;
        end
    end

    // Sample ring: the oldest entry is read as the sample is taken from the
    // queue and overwritten in the following cycle.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rd_data <= r_store[r_pos];
        end
        if (mem_we) begin
            r_store[r_pos] <= r_item.mv;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

>>> src/battery_level_monitor_unit.sv
// Battery level monitor: moving-average battery gauge with a screen timeout.
// A sample passes the back end states ACC, AVG, PSET, PCT and OUT, an activity request
// only OUT. AVG waits for the restoring divider of the average, one quotient bit per cycle
// over SUM_W = 13 + log2(WINDOW_DEPTH) bits. The back end takes one request at a time,
// and result stalls hold it in OUT.
// Reset is synchronous and active low; the sample ring is not cleared.
module battery_level_monitor_unit #(
    parameter int WINDOW_DEPTH = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration port.
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // Input request channel.
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_operation,
    input  logic [blm_pkg::ADC_W-1:0]     i_adc_millivolts,
    input  logic [blm_pkg::TIME_W-1:0]    i_now_ms,
    // Result channel.
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [blm_pkg::MV_W-1:0]      o_battery_millivolts,
    output logic [blm_pkg::PCT_W-1:0]     o_charge_percent,
    output logic                          o_low_battery,
    output logic                          o_screen_on
);

    // The only register is the screen timeout, at byte address zero. The upper
    // address bit selects the register index; byte offsets are ignored.
    logic [blm_pkg::TIME_W-1:0] r_timeout;
    logic                       cfg_write;

    blm_pkg::t_queue_head head;
    logic                 pop;
    blm_pkg::t_div_req    div_req;
    blm_pkg::t_div_rsp    div_rsp;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == blm_pkg::REG_TIMEOUT) ? r_timeout : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= blm_pkg::TIMEOUT_RESET;
        end else if (cfg_write && (paddr[2] == blm_pkg::REG_TIMEOUT)) begin
            r_timeout <= pwdata;
        end
    end

    // The front end doubles the ADC reading and queues the request, so up to two new
    // requests are taken while the back end is busy or its result waits.
    blm_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_operation      (i_operation),
        .i_adc_millivolts (i_adc_millivolts),
        .i_now_ms         (i_now_ms),
        .o_head           (head),
        .i_pop            (pop)
    );

    // The divider forms the window average over the samples filled so far.
    blm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // The back end owns all gauge state and the result register.
    blm_back #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_head               (head),
        .o_pop                (pop),
        .i_timeout_ms         (r_timeout),
        .o_div_req            (div_req),
        .i_div_rsp            (div_rsp),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_battery_millivolts (o_battery_millivolts),
        .o_charge_percent     (o_charge_percent),
        .o_low_battery        (o_low_battery),
        .o_screen_on          (o_screen_on)
    );

endmodule

>>> dv/battery_level_monitor_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the battery level monitor: directed and random requests,
// a scoreboard class that predicts each status result, and APB set-up of the screen timeout.
// Depends on blm_pkg and battery_level_monitor_unit from the RTL source folder.
module battery_level_monitor_unit_tb;

    localparam int DEPTH = 8;

    // Byte addresses on the configuration port. The second one lies beyond the register
    // list, so a write to it must leave every setting as it was.
    localparam logic [2:0] ADDR_TIMEOUT = 3'(4 * int'(blm_pkg::REG_TIMEOUT));
    localparam logic [2:0] ADDR_UNUSED  = 3'd4;

    // One status result as the block reports it.
    typedef struct packed {
        logic [blm_pkg::MV_W-1:0]  mv;
        logic [blm_pkg::PCT_W-1:0] pct;
        logic                      low;
        logic                      scr;
    } t_status;

    // The scoreboard keeps its own copy of the gauge state, works out the status that each
    // accepted request should produce and compares the results with it in order.
    class gauge_scoreboard;
        logic [blm_pkg::MV_W-1:0]   ring [DEPTH];
        int unsigned                wr_pos;
        int unsigned                fill;
        int unsigned                sum;
        logic [blm_pkg::TIME_W-1:0] last_touch;
        logic [blm_pkg::TIME_W-1:0] timeout;
        bit                         display;
        t_status                    held;
        t_status                    status_q [$];
        int                         errors;

        function new();
            wr_pos     = 0;
            fill       = 0;
            sum        = 0;
            last_touch = '0;
            timeout    = blm_pkg::TIMEOUT_RESET;
            display    = 1'b1;
            held.mv    = '0;
            held.pct   = blm_pkg::PCT_RESET;
            held.low   = 1'b0;
            held.scr   = 1'b1;
            errors     = 0;
        endfunction

        static function int charge_for(int v);
            if (v >= int'(blm_pkg::MV_FULL)) return 100;
            if (v >= int'(blm_pkg::MV_HIGH)) return 50 + (v - int'(blm_pkg::MV_HIGH)) * 50 / 330;
            if (v >= int'(blm_pkg::MV_MID)) return 10 + (v - int'(blm_pkg::MV_MID)) * 40 / 320;
            if (v >= int'(blm_pkg::MV_LOW)) return 5 + (v - int'(blm_pkg::MV_LOW)) * 5 / 200;
            if (v >= int'(blm_pkg::MV_EMPTY)) return (v - int'(blm_pkg::MV_EMPTY)) * 5 / 300;
            return 0;
        endfunction

        function void write_register(int idx, logic [31:0] data);
            if (idx == int'(blm_pkg::REG_TIMEOUT)) timeout = data;
        endfunction

        function void note_request(blm_pkg::t_op op, logic [blm_pkg::ADC_W-1:0] adc,
                                   logic [blm_pkg::TIME_W-1:0] now);
            logic [blm_pkg::MV_W-1:0]   mv;
            logic [blm_pkg::TIME_W-1:0] idle_ms;
            int unsigned                avg;
            t_status                    st;
            if (op == blm_pkg::OP_ACTIVITY) begin
                last_touch = now;
                display    = 1'b1;
            end else begin
                mv = {adc, 1'b0};
                // The oldest sample leaves the sum only once the ring is full.
                if (fill >= DEPTH) sum -= ring[wr_pos];
                else fill++;
                ring[wr_pos] = mv;
                sum += mv;
                wr_pos = (wr_pos + 1) % DEPTH;
                avg      = sum / fill;
                held.mv  = blm_pkg::MV_W'(avg);
                held.pct = blm_pkg::PCT_W'(charge_for(avg));
                held.low = (avg < blm_pkg::MV_LOW);
                idle_ms  = now - last_touch;
                if (display && idle_ms >= timeout) display = 1'b0;
            end
            st     = held;
            st.scr = display;
            status_q.push_back(st);
        endfunction

        function void report_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_status got);
            t_status want;
            if (status_q.size() == 0) begin
                $display("%0t: result with no request outstanding, expected none, actual %h",
                         $time, got);
                errors++;
            end else begin
                want = status_q.pop_front();
                report_field("battery_millivolts", want.mv, got.mv);
                report_field("charge_percent", want.pct, got.pct);
                report_field("low_battery", want.low, got.low);
                report_field("screen_on", want.scr, got.scr);
            end
        endfunction

        function int pending();
            return status_q.size();
        endfunction
    endclass

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [2:0]                 paddr;
    logic [31:0]                pwdata;
    logic [31:0]                prdata;
    logic                       pready;
    logic                       i_in_valid;
    logic                       o_in_stall;
    logic                       i_operation;
    logic [blm_pkg::ADC_W-1:0]  i_adc_millivolts;
    logic [blm_pkg::TIME_W-1:0] i_now_ms;
    logic                       o_out_valid;
    logic                       i_out_stall;
    logic [blm_pkg::MV_W-1:0]   o_battery_millivolts;
    logic [blm_pkg::PCT_W-1:0]  o_charge_percent;
    logic                       o_low_battery;
    logic                       o_screen_on;

    gauge_scoreboard            sb;
    int                         send_idle_pct;
    int                         stall_pct;
    // The time of the last accepted activity request and of the last request of any kind,
    // used to aim random timestamps at the timeout boundary.
    logic [blm_pkg::TIME_W-1:0] touch_ms;
    logic [blm_pkg::TIME_W-1:0] cursor_ms;

    battery_level_monitor_unit #(
        .WINDOW_DEPTH(DEPTH)
    ) u_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_operation         (i_operation),
        .i_adc_millivolts    (i_adc_millivolts),
        .i_now_ms            (i_now_ms),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_battery_millivolts(o_battery_millivolts),
        .o_charge_percent    (o_charge_percent),
        .o_low_battery       (o_low_battery),
        .o_screen_on         (o_screen_on)
    );

    // 100 MHz clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The result side stalls at random at the rate the current phase asks for.
    always @(posedge i_clk) begin
        i_out_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
    end

    // Every result taken at an edge is handed to the scoreboard. Outputs and the stall are
    // read before the edge's own updates land, so the sample is free of races.
    always @(posedge i_clk) begin
        t_status got;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            got.mv  = o_battery_millivolts;
            got.pct = o_charge_percent;
            got.low = o_low_battery;
            got.scr = o_screen_on;
            sb.check_result(got);
        end
    end

    // Presents one request and holds it until the block takes it. Valid is left high, so
    // back-to-back requests keep it up without a gap.
    task automatic send_request(blm_pkg::t_op op, logic [blm_pkg::ADC_W-1:0] adc,
                                logic [blm_pkg::TIME_W-1:0] now);
        i_in_valid       <= 1'b1;
        i_operation      <= op;
        i_adc_millivolts <= adc;
        i_now_ms         <= now;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        sb.note_request(op, adc, now);
        if (op == blm_pkg::OP_ACTIVITY) touch_ms = now;
        cursor_ms = now;
    endtask

    task automatic idle_cycle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Holds the request side off until every outstanding result has come back. At least
    // one cycle always passes, so valid is never lowered and raised in the same step.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Writes one address over APB, then reads the timeout register back and checks it.
    task automatic program_register(logic [2:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        sb.write_register(int'(addr) / 4, data);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        paddr   <= ADDR_TIMEOUT;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        sb.report_field("screen_timeout_ms", sb.timeout, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Random requests. Most samples sit in runs near one of the curve's knees, so that the
    // eight-sample average settles on and around each boundary; most timestamps either creep
    // forward or land within two milliseconds of the timeout after the last activity. A
    // share of fully random readings and timestamps stands for noise.
    task automatic run_phase(int count);
        int                         levels [7];
        int                         level;
        int                         tmp;
        int                         n;
        int                         pick;
        blm_pkg::t_op               op;
        logic [blm_pkg::ADC_W-1:0]  adc;
        logic [blm_pkg::TIME_W-1:0] now;
        levels = '{0, 1500, 1650, 1750, 1910, 2075, 4095};
        level  = levels[$urandom_range(0, 6)];
        for (n = 0; n < count; n++) begin
            while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) idle_cycle();
            // Now and then the sender waits for the block to empty completely.
            if ($urandom_range(0, 149) == 0) drain();
            op = ($urandom_range(0, 99) < 15) ? blm_pkg::OP_ACTIVITY : blm_pkg::OP_SAMPLE;
            if ($urandom_range(0, 9) == 0) level = levels[$urandom_range(0, 6)];
            if ($urandom_range(0, 99) < 20) begin
                adc = blm_pkg::ADC_W'($urandom);
            end else begin
                tmp = level + $urandom_range(0, 6) - 3;
                if (tmp < 0) tmp = 0;
                if (tmp > 4095) tmp = 4095;
                adc = blm_pkg::ADC_W'(tmp);
            end
            pick = $urandom_range(0, 99);
            if (pick < 45) now = cursor_ms + $urandom_range(0, 40);
            else if (pick < 75) now = touch_ms + sb.timeout + $urandom_range(0, 4) - 2;
            else if (pick < 90) now = cursor_ms + $urandom;
            else now = $urandom;
            send_request(op, adc, now);
        end
    endtask

    initial begin
        logic [blm_pkg::TIME_W-1:0] timeouts [6];
        int                         p;
        sb               = new();
        touch_ms         = '0;
        cursor_ms        = '0;
        send_idle_pct    = 0;
        stall_pct        = 0;
        i_rst_n          <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        i_in_valid       <= 1'b0;
        i_operation      <= blm_pkg::OP_SAMPLE;
        i_adc_millivolts <= '0;
        i_now_ms         <= '0;
        i_out_stall      <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests under the reset timeout of 10000 ms. The first is activity before
        // any sample, so the reset status must come back with the ADC value ignored.
        send_request(blm_pkg::OP_ACTIVITY, 12'd4095, 32'd0);
        send_request(blm_pkg::OP_SAMPLE, 12'd0, 32'd0);
        send_request(blm_pkg::OP_SAMPLE, 12'd4095, 32'd9999);
        // Exactly the timeout since the last activity switches the screen off.
        send_request(blm_pkg::OP_SAMPLE, 12'd4095, 32'd10000);
        // A sample with little elapsed time leaves a dark screen dark.
        send_request(blm_pkg::OP_SAMPLE, 12'd2075, 32'd5);
        send_request(blm_pkg::OP_ACTIVITY, 12'd0, 32'hFFFF_FFF0);
        // The elapsed time wraps past zero and reaches the timeout exactly.
        send_request(blm_pkg::OP_SAMPLE, 12'd1910, 32'h0000_2700);
        send_request(blm_pkg::OP_ACTIVITY, 12'd4095, 32'hFFFF_FFFF);
        send_request(blm_pkg::OP_SAMPLE, 12'd1750, 32'hFFFF_FFFF);
        // Enough further samples to wrap the ring and push out the oldest entries.
        send_request(blm_pkg::OP_SAMPLE, 12'd1650, 32'h0000_0000);
        send_request(blm_pkg::OP_SAMPLE, 12'd1500, 32'h0000_0001);
        send_request(blm_pkg::OP_SAMPLE, 12'd1499, 32'h0000_0002);
        send_request(blm_pkg::OP_SAMPLE, 12'd2074, 32'h0000_0003);
        send_request(blm_pkg::OP_SAMPLE, 12'd1, 32'h0000_0004);
        send_request(blm_pkg::OP_SAMPLE, 12'd2048, 32'h0000_0005);
        send_request(blm_pkg::OP_SAMPLE, 12'd4095, 32'h0000_0006);
        send_request(blm_pkg::OP_SAMPLE, 12'd0, 32'h0000_0007);

        // Random phases, each under its own timeout and one of four idling patterns. A zero timeout turns
        // the screen off on the first sample after activity; the largest one almost never.
        timeouts = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'd10000, $urandom, 32'd250};
        for (p = 0; p < 6; p++) begin
            drain();
            stall_pct     = 0;
            send_idle_pct = 0;
            if (p == 2) program_register(ADDR_UNUSED, $urandom);
            program_register(ADDR_TIMEOUT, timeouts[p]);
            case (p % 4)
                1: begin
                    send_idle_pct = 55;
                end
                2: begin
                    stall_pct = 55;
                end
                3: begin
                    send_idle_pct = 21;
                    stall_pct     = 21;
                end
                default: begin
                    send_idle_pct = 0;
                end
            endcase
            run_phase(205);
        end

        // Let the last results drain, then give the block a little longer in case a stray
        // result is still on its way.
        drain();
        stall_pct = 0;
        repeat (60) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Overall limit, far beyond the slowest correct run.
    initial begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

>>> files.f
src/blm_pkg.sv
src/blm_front.sv
src/blm_div.sv
src/blm_back.sv
src/battery_level_monitor_unit.sv
dv/battery_level_monitor_unit_tb.sv
